FILE: src/tcq_pkg.sv
// Shared types and constants for the two-class oldest-first queue.
// Used by tcq_class_fifo and two_class_oldest_first_queue; depends on nothing.
`default_nettype none

package tcq_pkg;

  // Queue geometry and field widths.
  localparam int QUEUE_DEPTH = 64;
  localparam int STAMP_BITS  = 16;
  localparam int ID_W        = 32;
  localparam int TAKE_W      = 2;
  localparam int STATUS_W    = 2;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Stream payload widths, rounded up to whole bytes.
  localparam int IN_TDATA_W  = ((ID_W + TAKE_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((ID_W + 7) / 8) * 8;

  typedef enum logic {
    CMD_ARRIVE = 1'b0,
    CMD_TAKE   = 1'b1
  } cmd_t;

  typedef enum logic [TAKE_W-1:0] {
    TAKE_OLDEST = 2'd0,
    TAKE_A      = 2'd1,
    TAKE_B      = 2'd2,
    TAKE_NONE   = 2'd3
  } take_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_STORED  = 2'd0,
    STAT_TAKEN   = 2'd1,
    STAT_EMPTY   = 2'd2,
    STAT_DROPPED = 2'd3
  } status_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  // Occupancy flags that one class queue reports to the control logic.
  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

endpackage

`default_nettype wire

FILE: src/two_class_oldest_first_queue.sv
// Two-class oldest-first queue: top level with the command sequencer.
// Depends on tcq_pkg and tcq_class_fifo.
//
// Usage:
//   Input beats arrive on the s_axis channel. tuser carries the command
//   (arrival or take request); tdata carries the identifier and the class
//   to take. A non-negative identifier joins class A, a negative one class B,
//   and each stored arrival is stamped from a shared wrapping counter.
//   Every input beat yields exactly one result beat on m_axis: tuser holds
//   the status (stored, taken, nothing available, dropped because full),
//   tdata the identifier taken, which is zero unless an item was taken.
//   In the idle state the command is registered while both queue memories
//   read their head entries; in the decision state the block decides,
//   updates the memory and pointers and loads the result register. A new
//   beat is accepted only in the idle state, so not while one is decided.
//   The result register lets the next beat be accepted while a result still
//   waits; if the receiver keeps stalling, the decision cycle holds and no
//   further beat is accepted. Reset empties both queues and clears the stamp
//   counter at once; no clearing pass is needed.
`default_nettype none

module two_class_oldest_first_queue (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // [31:0] arrival_id, [33:32] take_class, [39:34] zero
  input  wire logic [tcq_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // [0] cmd
  input  wire logic                              s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // [31:0] taken_id
  output logic      [tcq_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // [1:0] status
  output logic      [tcq_pkg::STATUS_W-1:0]      m_axis_tuser
);
  import tcq_pkg::*;

  typedef enum logic [1:0] {
    PICK_NONE = 2'd0,
    PICK_A    = 2'd1,
    PICK_B    = 2'd2
  } pick_t;

  state_t                state;
  state_t                state_next;
  cmd_t                  item_cmd;
  logic [ID_W-1:0]       item_id;
  take_t                 item_class;
  logic [STAMP_BITS-1:0] seq;

  logic                  accept;
  logic                  commit;

  logic [ID_W-1:0]       a_head_id;
  logic [ID_W-1:0]       b_head_id;
  logic [STAMP_BITS-1:0] a_head_stamp;
  logic [STAMP_BITS-1:0] b_head_stamp;
  fifo_stat_t            a_stat;
  fifo_stat_t            b_stat;
  logic                  push_a;
  logic                  push_b;
  logic                  pop_a;
  logic                  pop_b;

  logic [STAMP_BITS-1:0] stamp_diff;
  logic                  b_older;
  logic                  to_b;
  pick_t                 pick;
  status_t               res_status;
  logic [ID_W-1:0]       res_id;

  logic                  out_valid;
  status_t               out_status;
  logic [ID_W-1:0]       out_id;

  // Class queues.
  tcq_class_fifo u_class_a (
    .clk        (clk),
    .rst        (rst),
    .push       (push_a),
    .push_id    (item_id),
    .push_stamp (seq),
    .pop        (pop_a),
    .head_id    (a_head_id),
    .head_stamp (a_head_stamp),
    .stat       (a_stat)
  );

  tcq_class_fifo u_class_b (
    .clk        (clk),
    .rst        (rst),
    .push       (push_b),
    .push_id    (item_id),
    .push_stamp (seq),
    .pop        (pop_b),
    .head_id    (b_head_id),
    .head_stamp (b_head_stamp),
    .stat       (b_stat)
  );

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state: accept in idle, leave the decision cycle once the result fits.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!out_valid || m_axis_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    s_axis_tready = 1'b0;
    commit        = 1'b0;
    case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
      end
      ST_EXEC: begin
        commit = !out_valid || m_axis_tready;
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  assign accept = s_axis_tvalid && s_axis_tready;

  // Command register; payload needs no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_cmd   <= cmd_t'(s_axis_tuser);
      item_id    <= s_axis_tdata[ID_W-1:0];
      item_class <= take_t'(s_axis_tdata[ID_W+TAKE_W-1:ID_W]);
    end
  end

  // Age compare of the two heads: B wins only when strictly older.
  assign stamp_diff = a_head_stamp - b_head_stamp;
  assign b_older    = (stamp_diff != '0) && !stamp_diff[STAMP_BITS-1];
  assign to_b       = item_id[ID_W-1];

  // Choose which queue a take request pops.
  always_comb begin
    pick = PICK_NONE;
    case (item_class)
      TAKE_OLDEST: begin
        if (!a_stat.empty && !b_stat.empty) begin
          pick = b_older ? PICK_B : PICK_A;
        end else if (!a_stat.empty) begin
          pick = PICK_A;
        end else if (!b_stat.empty) begin
          pick = PICK_B;
        end
      end
      TAKE_A: begin
        if (!a_stat.empty) begin
          pick = PICK_A;
        end
      end
      TAKE_B: begin
        if (!b_stat.empty) begin
          pick = PICK_B;
        end
      end
      default: begin
        pick = PICK_NONE;
      end
    endcase
  end

  // Result and queue updates for the command in hand.
  always_comb begin
    res_status = STAT_EMPTY;
    res_id     = '0;
    push_a     = 1'b0;
    push_b     = 1'b0;
    pop_a      = 1'b0;
    pop_b      = 1'b0;
    if (item_cmd == CMD_ARRIVE) begin
      if (to_b) begin
        res_status = b_stat.full ? STAT_DROPPED : STAT_STORED;
        push_b     = commit && !b_stat.full;
      end else begin
        res_status = a_stat.full ? STAT_DROPPED : STAT_STORED;
        push_a     = commit && !a_stat.full;
      end
    end else begin
      case (pick)
        PICK_A: begin
          res_status = STAT_TAKEN;
          res_id     = a_head_id;
          pop_a      = commit;
        end
        PICK_B: begin
          res_status = STAT_TAKEN;
          res_id     = b_head_id;
          pop_b      = commit;
        end
        default: begin
          res_status = STAT_EMPTY;
        end
      endcase
    end
  end

  // Arrival stamp counter advances on every stored arrival.
  always_ff @(posedge clk) begin
    if (rst) begin
      seq <= '0;
    end else if (push_a || push_b) begin
      seq <= seq + 1'b1;
    end
  end

  // Result register toward the receiver.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_status <= res_status;
      out_id     <= res_id;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_status;
  assign m_axis_tdata  = OUT_TDATA_W'(out_id);

`ifndef ASSERT_OFF
  // A pop is only issued against a queue that holds an item.
  assert property (@(posedge clk) disable iff (rst)
    (pop_a |-> !a_stat.empty) and (pop_b |-> !b_stat.empty))
    else $error("pop issued on an empty class queue");

  // The identifier field is zero for every status other than taken.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser != STAT_TAKEN) |-> (m_axis_tdata == '0))
    else $error("nonzero identifier on a result without a take");

  // The stamp counter moves only after a stored arrival.
  assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && (seq != $past(seq)) |->
      $past(commit && item_cmd == CMD_ARRIVE && res_status == STAT_STORED))
    else $error("stamp counter advanced without a stored arrival");
`endif

endmodule

`default_nettype wire

FILE: src/tcq_class_fifo.sv
// One class queue: identifier and stamp memory with head, tail and count.
// Depends on tcq_pkg. The head entry is read every cycle into a register.
`default_nettype none

module tcq_class_fifo (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          push,
  input  wire logic [tcq_pkg::ID_W-1:0]       push_id,
  input  wire logic [tcq_pkg::STAMP_BITS-1:0] push_stamp,
  input  wire logic                          pop,
  output logic      [tcq_pkg::ID_W-1:0]       head_id,
  output logic      [tcq_pkg::STAMP_BITS-1:0] head_stamp,
  output tcq_pkg::fifo_stat_t                stat
);
  import tcq_pkg::*;

  localparam int ENTRY_W = STAMP_BITS + ID_W;

  logic [ENTRY_W-1:0] mem [QUEUE_DEPTH];
  logic [ENTRY_W-1:0] rd_data;
  logic [PTR_W-1:0]   head;
  logic [PTR_W-1:0]   tail;
  logic [CNT_W-1:0]   count;
  logic [PTR_W-1:0]   head_next;
  logic [PTR_W-1:0]   tail_next;

  // Pointer advance with wrap at the queue depth.
  assign head_next = (head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
  assign tail_next = (tail == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail + 1'b1;

  // Entry storage: write at the tail, registered read of the head.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[tail] <= {push_stamp, push_id};
    end
    rd_data <= mem[head];
  end

  assign head_id    = rd_data[ID_W-1:0];
  assign head_stamp = rd_data[ENTRY_W-1:ID_W];

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= tail_next;
      end
      if (pop) begin
        head <= head_next;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign stat.empty = (count == '0);
  assign stat.full  = (count == CNT_W'(QUEUE_DEPTH));

endmodule

`default_nettype wire

FILE: tb/tb_two_class_oldest_first_queue.sv
// Self-checking testbench for the two-class oldest-first queue.
// Drives s_axis with directed and random beats, checks every m_axis beat
// against an in-bench prediction. Depends on tcq_pkg and the RTL only.
`timescale 1ns / 100ps

module tb_two_class_oldest_first_queue;
  import tcq_pkg::*;

  localparam int CYCLE_LIMIT  = 2000000;
  localparam int RANDOM_ITEMS = 800;
  localparam int ROWS         = 25;

  // One waiting entry of a class queue: identifier and its arrival stamp.
  typedef struct packed {
    logic [ID_W-1:0]       id;
    logic [STAMP_BITS-1:0] stamp;
  } held_t;

  // One result beat as the block should produce it.
  typedef struct packed {
    status_t         status;
    logic [ID_W-1:0] id;
  } outcome_t;

  // Directed row: the outcome is typed in where known is set.
  typedef struct packed {
    logic            known;
    cmd_t            cmd;
    logic [ID_W-1:0] id;
    take_t           take;
    status_t         status;
    logic [ID_W-1:0] taken;
  } row_t;

  logic                   clk;
  logic                   rst;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [STATUS_W-1:0]    m_axis_tuser;

  // Predicted contents of both classes and the shared stamp counter.
  held_t                 class_a_q[$];
  held_t                 class_b_q[$];
  logic [STAMP_BITS-1:0] next_stamp;
  outcome_t              outcome_q[$];

  int  errors;
  int  n_items;
  int  n_checked;
  int  n_stored;
  int  n_taken;
  int  n_empty;
  int  n_dropped;
  int  n_wraps;
  int  deepest;
  int  cycle_count;
  bit  calm;

  row_t plan [0:ROWS-1] = '{
    '{1'b1, CMD_TAKE,   32'h0000_0000, TAKE_OLDEST, STAT_EMPTY,  32'h0000_0000},
    '{1'b1, CMD_TAKE,   32'hFFFF_FFFF, TAKE_A,      STAT_EMPTY,  32'h0000_0000},
    '{1'b1, CMD_TAKE,   32'h0000_0000, TAKE_B,      STAT_EMPTY,  32'h0000_0000},
    '{1'b1, CMD_TAKE,   32'h0000_0000, TAKE_NONE,   STAT_EMPTY,  32'h0000_0000},
    '{1'b1, CMD_ARRIVE, 32'h0000_0000, TAKE_OLDEST, STAT_STORED, 32'h0000_0000},
    '{1'b1, CMD_ARRIVE, 32'hFFFF_FFFF, TAKE_NONE,   STAT_STORED, 32'h0000_0000},
    '{1'b1, CMD_ARRIVE, 32'h7FFF_FFFF, TAKE_A,      STAT_STORED, 32'h0000_0000},
    '{1'b1, CMD_ARRIVE, 32'h8000_0000, TAKE_B,      STAT_STORED, 32'h0000_0000},
    '{1'b0, CMD_TAKE,   32'h0000_0000, TAKE_OLDEST, STAT_STORED, 32'h0000_0000},
    '{1'b0, CMD_TAKE,   32'h0000_0000, TAKE_OLDEST, STAT_STORED, 32'h0000_0000},
    '{1'b1, CMD_TAKE,   32'hFFFF_FFFF, TAKE_NONE,   STAT_EMPTY,  32'h0000_0000},
    '{1'b1, CMD_TAKE,   32'h0000_0000, TAKE_B,      STAT_TAKEN,  32'h8000_0000},
    '{1'b1, CMD_TAKE,   32'h0000_0000, TAKE_A,      STAT_TAKEN,  32'h7FFF_FFFF},
    '{1'b1, CMD_TAKE,   32'h0000_0000, TAKE_OLDEST, STAT_EMPTY,  32'h0000_0000},
    '{1'b1, CMD_ARRIVE, 32'h0000_0001, TAKE_OLDEST, STAT_STORED, 32'h0000_0000},
    '{1'b1, CMD_TAKE,   32'h0000_0000, TAKE_B,      STAT_EMPTY,  32'h0000_0000},
    '{1'b1, CMD_TAKE,   32'h0000_0000, TAKE_OLDEST, STAT_TAKEN,  32'h0000_0001},
    '{1'b1, CMD_ARRIVE, 32'hFFFF_FFFE, TAKE_OLDEST, STAT_STORED, 32'h0000_0000},
    '{1'b1, CMD_ARRIVE, 32'h1234_5678, TAKE_NONE,   STAT_STORED, 32'h0000_0000},
    '{1'b1, CMD_TAKE,   32'h0000_0000, TAKE_A,      STAT_TAKEN,  32'h1234_5678},
    '{1'b1, CMD_TAKE,   32'h0000_0000, TAKE_OLDEST, STAT_TAKEN,  32'hFFFF_FFFE},
    '{1'b1, CMD_ARRIVE, 32'h8000_0001, TAKE_OLDEST, STAT_STORED, 32'h0000_0000},
    '{1'b1, CMD_ARRIVE, 32'h0000_0002, TAKE_OLDEST, STAT_STORED, 32'h0000_0000},
    '{1'b0, CMD_TAKE,   32'h0000_0000, TAKE_OLDEST, STAT_STORED, 32'h0000_0000},
    '{1'b1, CMD_TAKE,   32'h0000_0000, TAKE_OLDEST, STAT_TAKEN,  32'h0000_0002}
  };

  two_class_oldest_first_queue u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Works out the result of one accepted beat and updates the predicted state.
  function automatic outcome_t shelter_step(input cmd_t cmd, input logic [ID_W-1:0] id,
                                            input take_t take);
    outcome_t              r;
    held_t                 h;
    logic [STAMP_BITS-1:0] diff;
    logic                  pick_a;
    logic                  pick_b;
    r.status = STAT_EMPTY;
    r.id     = '0;
    pick_a   = 1'b0;
    pick_b   = 1'b0;
    if (cmd == CMD_ARRIVE) begin
      // The sign bit of the identifier selects the class.
      if (!id[ID_W-1]) begin
        if (class_a_q.size() >= QUEUE_DEPTH) r.status = STAT_DROPPED;
        else begin
          class_a_q.insert(class_a_q.size(), held_t'{id, next_stamp});
          r.status = STAT_STORED;
        end
      end else begin
        if (class_b_q.size() >= QUEUE_DEPTH) r.status = STAT_DROPPED;
        else begin
          class_b_q.insert(class_b_q.size(), held_t'{id, next_stamp});
          r.status = STAT_STORED;
        end
      end
      if (r.status == STAT_STORED) begin
        next_stamp = next_stamp + 1'b1;
        if (next_stamp == '0) n_wraps++;
      end
      if (class_a_q.size() > deepest) deepest = class_a_q.size();
      if (class_b_q.size() > deepest) deepest = class_b_q.size();
    end else begin
      case (take)
        TAKE_OLDEST: begin
          if (class_a_q.size() != 0 && class_b_q.size() != 0) begin
            // Wrapping stamps: B wins only when its head is strictly older.
            diff   = class_a_q[0].stamp - class_b_q[0].stamp;
            pick_b = (diff != 0) && (diff < (1 << (STAMP_BITS - 1)));
            pick_a = !pick_b;
          end else begin
            pick_a = (class_a_q.size() != 0);
            pick_b = (class_a_q.size() == 0) && (class_b_q.size() != 0);
          end
        end
        TAKE_A: pick_a = (class_a_q.size() != 0);
        TAKE_B: pick_b = (class_b_q.size() != 0);
        default: ;
      endcase
      if (pick_a) begin
        h        = class_a_q.pop_front();
        r.id     = h.id;
        r.status = STAT_TAKEN;
      end else if (pick_b) begin
        h        = class_b_q.pop_front();
        r.id     = h.id;
        r.status = STAT_TAKEN;
      end
    end
    return r;
  endfunction

  // Idle length: mostly none or short, now and then long.
  function automatic int gap_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic report_mismatch(input string what, input logic [ID_W-1:0] got,
                                 input logic [ID_W-1:0] want);
    errors++;
    if (errors <= 40)
      $display("ERROR result beat %0d: %s got %h expected %h", n_checked, what, got, want);
  endtask

  // Presents one input beat, waits for it to be accepted and records its outcome.
  task automatic send_item(input cmd_t cmd, input logic [ID_W-1:0] id, input take_t take,
                           input logic known, input outcome_t typed);
    outcome_t predicted;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {{(IN_TDATA_W - ID_W - TAKE_W){1'b0}}, take, id};
    do @(posedge clk); while (s_axis_tready !== 1'b1);
    predicted = shelter_step(cmd, id, take);
    outcome_q.insert(outcome_q.size(), known ? typed : predicted);
    n_items++;
    case (predicted.status)
      STAT_STORED: n_stored++;
      STAT_TAKEN:  n_taken++;
      STAT_EMPTY:  n_empty++;
      default:     n_dropped++;
    endcase
  endtask

  task automatic pause_input();
    int n;
    n = gap_len();
    if (n > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Random beat; want_class 1 forces class A, 2 class B, anything else leaves the sign free.
  task automatic random_item(input int arrive_pct, input int want_class, input int oldest_pct);
    logic [ID_W-1:0] id;
    cmd_t            cmd;
    take_t           take;
    id = $urandom;
    if (want_class == 1) id[ID_W-1] = 1'b0;
    if (want_class == 2) id[ID_W-1] = 1'b1;
    cmd  = ($urandom_range(99) < arrive_pct) ? CMD_ARRIVE : CMD_TAKE;
    take = ($urandom_range(99) < oldest_pct) ? TAKE_OLDEST : take_t'($urandom_range(3));
    send_item(cmd, id, take, 1'b0, '0);
    pause_input();
  endtask

  // Stimulus: reset, directed rows, random episodes, final drain.
  initial begin : stimulus
    int kind;
    int pct;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= CMD_ARRIVE;
    rst           <= 1'b1;
    next_stamp = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows: empty queues, extreme identifiers, every take class.
    for (int i = 0; i < ROWS; i++) begin
      send_item(plan[i].cmd, plan[i].id, plan[i].take, plan[i].known,
                '{plan[i].status, plan[i].taken});
      pause_input();
    end

    // Random episodes: mixed traffic, fill bursts that overflow a class, drains.
    while (n_items < ROWS + RANDOM_ITEMS) begin
      calm = ($urandom_range(4) == 0);
      kind = $urandom_range(9);
      if (kind == 0) begin
        while (class_a_q.size() < QUEUE_DEPTH) random_item(100, 1, 50);
        repeat ($urandom_range(1, 4)) random_item(100, 1, 50);
      end else if (kind == 1) begin
        while (class_b_q.size() < QUEUE_DEPTH) random_item(100, 2, 50);
        repeat ($urandom_range(1, 4)) random_item(100, 2, 50);
      end else if (kind == 2) begin
        while (class_a_q.size() != 0 || class_b_q.size() != 0) random_item(0, 0, 40);
        repeat ($urandom_range(1, 3)) random_item(0, 0, 25);
      end else begin
        pct = $urandom_range(30, 70);
        repeat (20) random_item(pct, 0, 50);
      end
    end
    calm = 1'b0;

    // Empty both classes so every stored identifier is read back once.
    while (class_a_q.size() != 0 || class_b_q.size() != 0) random_item(0, 0, 60);
    s_axis_tvalid <= 1'b0;

    while (outcome_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Checked %0d result beats for %0d input beats: %0d stored, %0d taken, %0d empty,",
             n_checked, n_items, n_stored, n_taken, n_empty);
    $display("%0d dropped on a full class; stamp counter wrapped %0d time(s), deepest class %0d.",
             n_dropped, n_wraps, deepest);
    if (errors == 0) begin
      $display("two_class_oldest_first_queue: match");
    end else begin
      $display("two_class_oldest_first_queue: mismatch");
    end
    $finish;
  end

  // Receiver: random stalls between accepted result beats.
  initial begin : receiver
    int n;
    m_axis_tready <= 1'b0;
    wait (!rst);
    @(posedge clk);
    forever begin
      n = gap_len();
      if (n > 0) begin
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!(m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1));
    end
  end

  // Compare each accepted result beat with the oldest outstanding outcome.
  always @(posedge clk) begin
    outcome_t want;
    if (!rst && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
      if (outcome_q.size() == 0) begin
        report_mismatch("result beat with nothing outstanding, tdata", m_axis_tdata, '0);
      end else begin
        want = outcome_q.pop_front();
        if (m_axis_tuser !== want.status)
          report_mismatch("status", ID_W'(m_axis_tuser), ID_W'(want.status));
        if (m_axis_tdata !== want.id)
          report_mismatch("taken_id", m_axis_tdata, want.id);
        n_checked++;
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("Run stopped after %0d cycles with %0d results outstanding.",
             cycle_count, outcome_q.size());
    $display("two_class_oldest_first_queue: mismatch");
    $finish;
  end

endmodule
